// ===== rtl/bhpq_pkg.sv =====
// ----------------------------------------------------------------------------
// bhpq_pkg
// Shared types, codes and the ordering function of the priority queue.
// ----------------------------------------------------------------------------
package bhpq_pkg;

  // Action codes; the fourth code does nothing
  typedef enum logic [1:0] {
    ACT_PUSH  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_CLEAR = 2'd2
  } action_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Command transfer
  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] item_value;
    logic [15:0]        item_id;
  } cmd_t;

  // Response transfer
  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] top_value;
    logic [15:0]        top_id;
    logic [7:0]         count;
    logic               is_empty;
  } rsp_t;

  // Broadcast control to every cell
  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctl_t;

  // True when entry a is served strictly before entry b
  function automatic logic served_before(
    input logic signed [31:0] a_value,
    input logic [31:0]        a_id,
    input logic signed [31:0] b_value,
    input logic [31:0]        b_id
  );
    if (a_value != b_value) begin
      return a_value > b_value;
    end
    return a_id < b_id;
  endfunction

endpackage

// ===== rtl/bhpq_cell.sv =====
// ----------------------------------------------------------------------------
// bhpq_cell
// One slot of the sorted row: compares the pushed entry with its own and
// takes the pushed entry or its left neighbor's on insert, its right neighbor's on pop.
// ----------------------------------------------------------------------------
module bhpq_cell #(
  parameter int ID_BITS = 16
) (
  input  logic                  clk,
  input  bhpq_pkg::cell_ctl_t   ctl,
  input  logic                  occupied,
  input  logic signed [31:0]    new_value,
  input  logic [ID_BITS-1:0]    new_id,
  input  logic                  ins_prev,
  input  logic signed [31:0]    prev_value,
  input  logic [ID_BITS-1:0]    prev_id,
  input  logic signed [31:0]    next_value,
  input  logic [ID_BITS-1:0]    next_id,
  output logic                  ins,
  output logic signed [31:0]    value,
  output logic [ID_BITS-1:0]    id
);
  import bhpq_pkg::*;

  // New entry lands here or further left when it beats this slot
  assign ins = !occupied ||
               served_before(new_value, 32'(new_id), value, 32'(id));

  // Insert shifts right, pop shifts left
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      if (ins) begin
        value <= ins_prev ? prev_value : new_value;
        id    <= ins_prev ? prev_id    : new_id;
      end
    end else if (ctl.pop) begin
      value <= next_value;
      id    <= next_id;
    end
  end

endmodule

// ===== rtl/binary_heap_priority_queue.sv =====
// ----------------------------------------------------------------------------
// binary_heap_priority_queue
// Bounded priority queue of (value, id) entries kept as a sorted row of
// cells; largest value first, smallest id on equal values.
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+------------------------------------
//   command | cmd_valid | cmd_stall | cmd: action, item_value, item_id
//   result  | rsp_valid | rsp_stall | rsp: status, top, count, is_empty
//
// One command per cycle unless a stalled result holds cmd_stall; the result
// appears in the output register on the next cycle. All cells compare the
// pushed entry with their own in parallel; no command walks the row.
// A stalled result holds cmd_stall high until it is taken.
// Reset empties the queue at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module binary_heap_priority_queue #(
  parameter int CAPACITY = 128,
  parameter int ID_BITS  = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_stall,
  input  bhpq_pkg::cmd_t cmd,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output bhpq_pkg::rsp_t rsp
);
  import bhpq_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  logic                     accept;
  logic                     full;
  logic                     is_push;
  logic                     is_pop;
  logic                     is_clear;
  cell_ctl_t                ctl;
  logic [CW-1:0]            count;
  logic [CW-1:0]            count_next;
  rsp_t                     rsp_next;
  logic [ID_BITS-1:0]       new_id;
  logic signed [31:0]       cell_value [CAPACITY];
  logic [ID_BITS-1:0]       cell_id    [CAPACITY];
  logic                     cell_ins   [CAPACITY];

  // Output register parts the two sides
  assign cmd_stall = rsp_valid && rsp_stall;
  assign accept    = cmd_valid && !cmd_stall;

  assign is_push  = cmd.action == ACT_PUSH;
  assign is_pop   = cmd.action == ACT_POP;
  assign is_clear = cmd.action == ACT_CLEAR;
  assign full     = count == CW'(CAPACITY);
  assign new_id   = ID_BITS'(cmd.item_id);

  assign ctl.push = accept && is_push && !full;
  assign ctl.pop  = accept && is_pop && (count != '0);

  // Row of cells, slot 0 holds the best entry
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CW-1:0] IDX = CW'(i);
    logic                  ins_prev;
    logic signed [31:0]    prev_value;
    logic [ID_BITS-1:0]    prev_id;
    logic signed [31:0]    next_value;
    logic [ID_BITS-1:0]    next_id;

    if (i == 0) begin : g_first
      assign ins_prev   = 1'b0;
      assign prev_value = cmd.item_value;
      assign prev_id    = new_id;
    end else begin : g_mid
      assign ins_prev   = cell_ins[i-1];
      assign prev_value = cell_value[i-1];
      assign prev_id    = cell_id[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_value = cell_value[i];
      assign next_id    = cell_id[i];
    end else begin : g_inner
      assign next_value = cell_value[i+1];
      assign next_id    = cell_id[i+1];
    end

    bhpq_cell #(
      .ID_BITS (ID_BITS)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occupied   (count > IDX),
      .new_value  (cmd.item_value),
      .new_id     (new_id),
      .ins_prev   (ins_prev),
      .prev_value (prev_value),
      .prev_id    (prev_id),
      .next_value (next_value),
      .next_id    (next_id),
      .ins        (cell_ins[i]),
      .value      (cell_value[i]),
      .id         (cell_id[i])
    );
  end

  // Next count and the result of this command
  always_comb begin
    count_next         = count;
    rsp_next.status    = ST_OK;
    rsp_next.top_value = '0;
    rsp_next.top_id    = '0;
    if (count != '0) begin
      rsp_next.top_value = cell_value[0];
      rsp_next.top_id    = 16'(cell_id[0]);
    end
    if (is_push) begin
      if (full) begin
        rsp_next.status = ST_FULL;
      end else begin
        count_next = count + 1'b1;
        if (cell_ins[0]) begin
          rsp_next.top_value = cmd.item_value;
          rsp_next.top_id    = 16'(new_id);
        end
      end
    end else if (is_pop) begin
      if (count == '0) begin
        rsp_next.status = ST_EMPTY;
      end else begin
        count_next = count - 1'b1;
      end
    end else if (is_clear) begin
      count_next         = '0;
      rsp_next.top_value = '0;
      rsp_next.top_id    = '0;
    end
    rsp_next.count    = 8'(count_next);
    rsp_next.is_empty = count_next == '0;
  end

  // Fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

  // Fill never exceeds the row
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("fill count beyond capacity");

  // First two slots stay in serving order
  a_sorted_head: assert property (@(posedge clk) disable iff (rst)
    (count > CW'(1)) |->
      !served_before(cell_value[1], 32'(cell_id[1]),
                     cell_value[0], 32'(cell_id[0])))
    else $error("head cells out of order");

  // Pop on an empty queue reports empty and keeps the fill
  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    (accept && is_pop && count == '0) |=>
      (rsp_valid && rsp.status == ST_EMPTY && count == '0))
    else $error("pop on empty queue mishandled");

  // Accepted push that fits raises the fill by one
  a_push_count: assert property (@(posedge clk) disable iff (rst)
    (accept && is_push && !full) |=> (count == $past(count) + 1'b1))
    else $error("push did not grow the fill");

endmodule

// ===== verif/bhpq_checker.sv =====
// ----------------------------------------------------------------------------
// bhpq_checker
// Watches both channels of the priority queue. A local heap predicts each
// result from the command transfers; result transfers are compared in order.
// ----------------------------------------------------------------------------
module bhpq_checker #(
  parameter int CAPACITY = 128
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  input  logic           cmd_stall,
  input  bhpq_pkg::cmd_t cmd,
  input  logic           rsp_valid,
  input  logic           rsp_stall,
  input  bhpq_pkg::rsp_t rsp,
  output int             fails,
  output int             outstanding,
  output int             checked,
  output int             full_rejects,
  output int             empty_pops,
  output int             peak_fill
);
  timeunit 1ns;
  timeprecision 1ps;
  import bhpq_pkg::*;

  // Shadow heap: parent always ranks at or above its children
  logic signed [31:0] heap_value [CAPACITY];
  logic [15:0]        heap_id    [CAPACITY];
  int                 heap_fill;

  rsp_t pending_rsp [$];
  rsp_t predicted;
  rsp_t oldest;

  // Larger value wins; smaller id breaks a tie
  function automatic bit outranks(logic signed [31:0] av, logic [15:0] ai,
                                  logic signed [31:0] bv, logic [15:0] bi);
    if (av != bv) begin
      return av > bv;
    end
    return ai < bi;
  endfunction

  task automatic swap_slots(int a, int b);
    logic signed [31:0] tv;
    logic [15:0]        ti;
    tv = heap_value[a]; ti = heap_id[a];
    heap_value[a] = heap_value[b]; heap_id[a] = heap_id[b];
    heap_value[b] = tv; heap_id[b] = ti;
  endtask

  // Apply one command to the shadow heap and build its result
  task automatic apply_cmd(input cmd_t c, output rsp_t r);
    int cur;
    int up;
    int kid;
    bit took;
    r = '0;
    r.status = ST_OK;
    took = 1'b0;
    case (c.action)
      ACT_PUSH: begin
        if (heap_fill >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          cur = heap_fill;
          heap_value[cur] = c.item_value;
          heap_id[cur] = c.item_id;
          while (cur > 0) begin
            up = (cur - 1) / 2;
            if (!outranks(heap_value[cur], heap_id[cur], heap_value[up], heap_id[up]))
              break;
            swap_slots(cur, up);
            cur = up;
          end
          heap_fill++;
        end
      end
      ACT_POP: begin
        if (heap_fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.top_value = heap_value[0];
          r.top_id = heap_id[0];
          took = 1'b1;
          heap_fill--;
          heap_value[0] = heap_value[heap_fill];
          heap_id[0] = heap_id[heap_fill];
          cur = 0;
          while (cur * 2 + 1 < heap_fill) begin
            kid = cur * 2 + 1;
            if (kid + 1 < heap_fill &&
                !outranks(heap_value[kid], heap_id[kid], heap_value[kid + 1], heap_id[kid + 1]))
              kid = kid + 1;
            if (!outranks(heap_value[kid], heap_id[kid], heap_value[cur], heap_id[cur]))
              break;
            swap_slots(cur, kid);
            cur = kid;
          end
        end
      end
      ACT_CLEAR: heap_fill = 0;
      default: ;
    endcase
    // Anything but a pop reports the root, zeros when empty
    if (!took && c.action != ACT_POP && heap_fill > 0) begin
      r.top_value = heap_value[0];
      r.top_id = heap_id[0];
    end
    r.count = 8'(heap_fill);
    r.is_empty = (heap_fill == 0);
  endtask

  task automatic mismatch(string field, logic signed [63:0] want, logic signed [63:0] got);
    $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
    fails++;
  endtask

  // Compare result transfers first: a command taken at this edge is newer
  always @(posedge clk) begin
    if (rst) begin
      heap_fill = 0;
      pending_rsp.delete();
      outstanding <= 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (pending_rsp.size() == 0) begin
          $display("%0t: result transfer with no command pending: %p", $time, rsp);
          fails++;
        end else begin
          oldest = pending_rsp.pop_front();
          checked++;
          if (rsp.status !== oldest.status) mismatch("status", oldest.status, rsp.status);
          if (rsp.top_value !== oldest.top_value)
            mismatch("top_value", oldest.top_value, rsp.top_value);
          if (rsp.top_id !== oldest.top_id) mismatch("top_id", oldest.top_id, rsp.top_id);
          if (rsp.count !== oldest.count) mismatch("count", oldest.count, rsp.count);
          if (rsp.is_empty !== oldest.is_empty)
            mismatch("is_empty", oldest.is_empty, rsp.is_empty);
        end
      end
      if (cmd_valid && !cmd_stall) begin
        apply_cmd(cmd, predicted);
        pending_rsp.push_back(predicted);
        if (predicted.status == ST_FULL) full_rejects++;
        if (predicted.status == ST_EMPTY) empty_pops++;
        if (heap_fill > peak_fill) peak_fill = heap_fill;
      end
      outstanding <= pending_rsp.size();
    end
  end

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives commands into the priority queue: a directed opening, then fill,
// drain and mixed stretches under changing idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bhpq_pkg::*;

  localparam int         CAPACITY       = 128;
  localparam int         TOTAL_ITEMS    = 825;
  localparam int         WATCHDOG_LIMIT = 2000;
  localparam logic [1:0] ACT_NOP        = 2'd3;
  localparam int         MODE_FILL      = 0;
  localparam int         MODE_DRAIN     = 1;
  localparam int         MODE_MIX       = 2;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic cmd_valid = 1'b0;
  logic rsp_stall = 1'b0;
  cmd_t cmd       = '0;
  logic cmd_stall;
  logic rsp_valid;
  rsp_t rsp;

  int fails, outstanding, checked, full_rejects, empty_pops, peak_fill;
  int idle_pct  = 0;
  int stall_pct = 0;
  int sent      = 0;
  int quiet     = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  binary_heap_priority_queue #(.CAPACITY(CAPACITY)) dut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  bhpq_checker #(.CAPACITY(CAPACITY)) chk (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .fails(fails), .outstanding(outstanding), .checked(checked),
    .full_rejects(full_rejects), .empty_pops(empty_pops), .peak_fill(peak_fill)
  );

  // Result side back-pressure
  always @(posedge clk) begin
    rsp_stall <= ($urandom_range(99) < stall_pct);
  end

  // Watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog: no transfer for %0d cycles", $time, quiet);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // One command transfer, with random idle cycles ahead of it
  task automatic send_cmd(logic [1:0] act, logic signed [31:0] val, logic [15:0] id);
    if ($urandom_range(99) < idle_pct) begin
      cmd_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    cmd_valid <= 1'b1;
    cmd <= '{action: act, item_value: val, item_id: id};
    do @(posedge clk); while (cmd_stall);
    sent++;
  endtask

  // Hold off until every result has been taken
  task automatic await_drain();
    cmd_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  function automatic logic [1:0] pick_action(int mode);
    int r;
    r = $urandom_range(99);
    case (mode)
      MODE_FILL:  return (r < 90) ? ACT_PUSH : (r < 98) ? ACT_POP : ACT_NOP;
      MODE_DRAIN: return (r < 88) ? ACT_POP : (r < 96) ? ACT_PUSH : (r < 98) ? ACT_NOP : ACT_CLEAR;
      default:    return (r < 45) ? ACT_PUSH : (r < 85) ? ACT_POP : (r < 90) ? ACT_CLEAR : ACT_NOP;
    endcase
  endfunction

  // Extremes, a narrow band for ties, and full-range values
  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(15))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return 32'sd0;
      3:       return -32'sd1;
      4, 5, 6, 7, 8: return $signed({29'd0, 3'($urandom_range(4))}) - 32'sd2;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] rand_id();
    case ($urandom_range(7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2, 3, 4: return 16'($urandom_range(3));
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int seg;
    int mode;
    seg = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty-queue cases, extremes, ties, drain, clear
    send_cmd(ACT_POP, 0, 0);
    send_cmd(ACT_CLEAR, 0, 0);
    send_cmd(ACT_NOP, 0, 0);
    send_cmd(ACT_PUSH, 32'sh7FFF_FFFF, 16'hFFFF);
    send_cmd(ACT_PUSH, 32'sh8000_0000, 16'h0000);
    send_cmd(ACT_PUSH, 32'sd0, 16'd100);
    send_cmd(ACT_PUSH, -32'sd1, 16'd7);
    send_cmd(ACT_PUSH, 32'sh7FFF_FFFF, 16'h0000);
    send_cmd(ACT_PUSH, 32'sh7FFF_FFFF, 16'h0000);
    send_cmd(ACT_NOP, 32'sd55, 16'd55);
    send_cmd(ACT_PUSH, 32'sd0, 16'd99);
    repeat (7) send_cmd(ACT_POP, 0, 0);
    send_cmd(ACT_POP, 0, 0);
    send_cmd(ACT_PUSH, 32'sd5, 16'd5);
    send_cmd(ACT_CLEAR, 0, 0);
    send_cmd(ACT_POP, 0, 0);
    send_cmd(ACT_PUSH, 32'sh8000_0000, 16'hFFFF);
    send_cmd(ACT_NOP, 0, 0);
    send_cmd(ACT_CLEAR, 0, 0);
    await_drain();

    // Random stretches; each ends with a full drain of results
    while (sent < TOTAL_ITEMS) begin
      mode = seg % 3;
      case (seg % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 82; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 82; end
        default: begin idle_pct = 7; stall_pct = 7; end
      endcase
      repeat ((mode == MODE_MIX) ? 60 : 170) send_cmd(pick_action(mode), rand_value(), rand_id());
      await_drain();
      seg++;
    end

    repeat (32) @(posedge clk);
    $display("Ran %0d commands over %0d stretches; %0d results checked, peak fill %0d of %0d",
             sent, seg, checked, peak_fill, CAPACITY);
    $display("Pushes rejected on a full queue: %0d, pops on an empty queue: %0d",
             full_rejects, empty_pops);
    if (fails == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/bhpq_pkg.sv
rtl/bhpq_cell.sv
rtl/binary_heap_priority_queue.sv
verif/bhpq_checker.sv
verif/tb_top.sv
